// ----- src/pan_tilt_pid_laser_tracker_unit_assert.svh -----
// Assertion macros for the pan/tilt laser tracker.
`ifndef PAN_TILT_PID_LASER_TRACKER_UNIT_ASSERT_SVH
`define PAN_TILT_PID_LASER_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ptl_pkg.sv -----
// Shared types, constants and functions of the pan/tilt laser tracker.
package ptl_pkg;

   localparam int ACC_BITS_DEF    = 21;
   localparam int COORD_LIMIT_DEF = 250;

   localparam int COORD_W = 8;
   localparam int GAIN_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int CMP_W   = 8;
   localparam int HITS_W  = 8;
   localparam int ERR_W   = 9;
   localparam int DERR_W  = 10;
   localparam int CSR_IDX_W = 2;
   localparam int FRAC_SHIFT = 4;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;
   localparam logic [ANGLE_W-1:0] ANGLE_MID = 16'd23040;

   localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd410;
   localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;

   localparam logic [HITS_W-1:0] HITS_MAX = 8'd255;

   // compare = 50 + floor(deg * 10 / 9), 10/9 as Q.16 set slightly above its exact value
   localparam logic [CMP_W-1:0] CMP_BASE  = 8'd50;
   localparam logic [CMP_W-1:0] CMP_TOP   = 8'd250;
   localparam int               RECIP_W   = 17;
   localparam logic [RECIP_W-1:0] CMP_RECIP = 17'd72820;
   localparam int               RECIP_SH  = 16;
   localparam int               CMP_PROD_W = COORD_W + RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P = 2'd0,
      CSR_GAIN_I = 2'd1,
      CSR_GAIN_D = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
   } gains_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
      logic trk0;
      logic trk3;
   } stage_ctrl_type;

   function automatic logic [CMP_W-1:0] compare_of(input logic [ANGLE_W-1:0] angle);
      logic [COORD_W-1:0]    deg;
      logic [CMP_PROD_W-1:0] prod;
      deg  = angle[ANGLE_W-1:ANGLE_W-COORD_W];
      prod = CMP_PROD_W'(deg) * CMP_PROD_W'(CMP_RECIP);
      return CMP_BASE + prod[RECIP_SH+CMP_W-1:RECIP_SH];
   endfunction

endpackage

// ----- src/ptl_stream_ifs.sv -----
// Request and response channel interfaces of the pan/tilt laser tracker.
interface ptl_req_if;
   logic                        valid;
   logic                        ready;
   logic [ptl_pkg::COORD_W-1:0] target_x;
   logic [ptl_pkg::COORD_W-1:0] target_y;
   logic [ptl_pkg::COORD_W-1:0] spot_x;
   logic [ptl_pkg::COORD_W-1:0] spot_y;

   modport source (output valid, target_x, target_y, spot_x, spot_y, input ready);
   modport sink   (input valid, target_x, target_y, spot_x, spot_y, output ready);
endinterface

interface ptl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ptl_pkg::ANGLE_W-1:0] pan_angle;
   logic [ptl_pkg::ANGLE_W-1:0] tilt_angle;
   logic [ptl_pkg::CMP_W-1:0]   pan_compare;
   logic [ptl_pkg::CMP_W-1:0]   tilt_compare;
   logic                        tracked;
   logic                        hit_pulse;
   logic [ptl_pkg::HITS_W-1:0]  hit_count;

   modport source (output valid, pan_angle, tilt_angle, pan_compare, tilt_compare,
                   tracked, hit_pulse, hit_count, input ready);
   modport sink   (input valid, pan_angle, tilt_angle, pan_compare, tilt_compare,
                   tracked, hit_pulse, hit_count, output ready);
endinterface

// ----- src/ptl_axis_loop.sv -----
// One PID servo axis: error sum, gain products, loop sum and clamped angle update.
module ptl_axis_loop #(
   parameter int ACC_BITS = ptl_pkg::ACC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ptl_pkg::stage_ctrl_type          ctrl,
   input  ptl_pkg::gains_type               gains,
   input  logic [ptl_pkg::COORD_W-1:0]      target,
   input  logic [ptl_pkg::COORD_W-1:0]      spot,
   output logic [ptl_pkg::ANGLE_W-1:0]      angle
);
   localparam int AW   = ACC_BITS;
   localparam int EW   = ptl_pkg::ERR_W;
   localparam int DW   = ptl_pkg::DERR_W;
   localparam int GW   = ptl_pkg::GAIN_W;
   localparam int PPW  = GW + EW;
   localparam int PIW  = GW + AW;
   localparam int PDW  = GW + DW;
   localparam int SW   = AW + GW + 2;
   localparam int OW   = SW - ptl_pkg::FRAC_SHIFT;
   localparam int PW   = OW + 1;
   localparam int ANW  = ptl_pkg::ANGLE_W;

   localparam logic [AW-1:0] ACC_MAXV = {1'b0, {(AW-1){1'b1}}};
   localparam logic [AW-1:0] ACC_MINV = {1'b1, {(AW-1){1'b0}}};

   // stage 1: error, error sum, difference
   logic signed [EW-1:0] err;
   logic signed [AW:0]   acc_sum;
   logic        [AW-1:0] acc_new;
   logic signed [DW-1:0] derr;
   logic        [AW-1:0] acc_ff;
   logic        [EW-1:0] prev_err_ff;

   logic signed [EW-1:0] err1_ff;
   logic signed [AW-1:0] acc1_ff;
   logic signed [DW-1:0] derr1_ff;

   assign err     = $signed({1'b0, target}) - $signed({1'b0, spot});
   assign acc_sum = $signed({{(AW+1-EW){err[EW-1]}}, err})
                  + $signed({acc_ff[AW-1], acc_ff});
   always_comb begin
      if (acc_sum[AW] != acc_sum[AW-1]) begin
         acc_new = acc_sum[AW] ? ACC_MINV : ACC_MAXV;
      end else begin
         acc_new = acc_sum[AW-1:0];
      end
   end
   assign derr = $signed({err[EW-1], err}) - $signed({prev_err_ff[EW-1], prev_err_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         prev_err_ff <= '0;
      end else if (ctrl.ld1 && ctrl.trk0) begin
         acc_ff      <= acc_new;
         prev_err_ff <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld1) begin
         err1_ff  <= err;
         acc1_ff  <= $signed(acc_new);
         derr1_ff <= derr;
      end
   end

   // stage 2: gain products
   logic signed [GW-1:0]  gp;
   logic signed [GW-1:0]  gi;
   logic signed [GW-1:0]  gd;
   logic signed [PPW-1:0] prod_p_ff;
   logic signed [PIW-1:0] prod_i_ff;
   logic signed [PDW-1:0] prod_d_ff;

   assign gp = $signed(gains.gain_p);
   assign gi = $signed(gains.gain_i);
   assign gd = $signed(gains.gain_d);

   always_ff @(posedge clock) begin
      if (ctrl.ld2) begin
         prod_p_ff <= PPW'(gp) * PPW'(err1_ff);
         prod_i_ff <= PIW'(gi) * PIW'(acc1_ff);
         prod_d_ff <= PDW'(gd) * PDW'(derr1_ff);
      end
   end

   // stage 3: loop sum, Q.12 to Q8.8 with floor
   logic signed [SW-1:0] loop_sum;
   logic signed [OW-1:0] loop_out_ff;

   assign loop_sum = $signed({{(SW-PPW){prod_p_ff[PPW-1]}}, prod_p_ff})
                   + $signed({{(SW-PIW){prod_i_ff[PIW-1]}}, prod_i_ff})
                   + $signed({{(SW-PDW){prod_d_ff[PDW-1]}}, prod_d_ff});

   always_ff @(posedge clock) begin
      if (ctrl.ld3) begin
         loop_out_ff <= loop_sum[SW-1:ptl_pkg::FRAC_SHIFT];
      end
   end

   // stage 4: angle update and clamp
   logic [ANW-1:0]      pos_ff;
   logic signed [PW-1:0] pos_diff;
   logic [ANW-1:0]      pos_clamped;
   logic [ANW-1:0]      angle4_ff;

   assign pos_diff = $signed({{(PW-ANW){1'b0}}, pos_ff})
                   - $signed({loop_out_ff[OW-1], loop_out_ff});
   always_comb begin
      if (pos_diff[PW-1]) begin
         pos_clamped = '0;
      end else if (pos_diff > $signed({{(PW-ANW){1'b0}}, ptl_pkg::ANGLE_MAX})) begin
         pos_clamped = ptl_pkg::ANGLE_MAX;
      end else begin
         pos_clamped = pos_diff[ANW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ptl_pkg::ANGLE_MID;
      end else if (ctrl.ld4 && ctrl.trk3) begin
         pos_ff <= pos_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld4) begin
         angle4_ff <= ctrl.trk3 ? pos_clamped : pos_ff;
      end
   end

   assign angle = angle4_ff;

endmodule

// ----- src/pan_tilt_pid_laser_tracker_unit.sv -----
// Pan/tilt laser tracker: two PID servo loops with hit detection.
// Pipeline: an accepted item passes the input register, then error sum, products,
//   loop sum, angle update and output register before result valid.
// Throughput: one item per cycle; each stage holds only while the stage after it is full.
// Reset (synchronous): clears stage valids, error sums, last errors, hit count and
//   previous spot, sets both angles to 90 degrees and gains to their defaults.
`include "pan_tilt_pid_laser_tracker_unit_assert.svh"

module pan_tilt_pid_laser_tracker_unit #(
   parameter int ACC_BITS    = ptl_pkg::ACC_BITS_DEF,
   parameter int COORD_LIMIT = ptl_pkg::COORD_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ptl_req_if.sink                           req_ch,
   ptl_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [ptl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptl_pkg::GAIN_W-1:0]        csr_wdata
);
   localparam int CW = ptl_pkg::COORD_W;
   localparam int HW = ptl_pkg::HITS_W;
   localparam logic [CW-1:0] LIM = CW'(COORD_LIMIT);

   // configuration
   ptl_pkg::gains_type gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.gain_p <= ptl_pkg::GAIN_P_RST;
         gains_ff.gain_i <= ptl_pkg::GAIN_I_RST;
         gains_ff.gain_d <= ptl_pkg::GAIN_D_RST;
      end else if (csr_write_en) begin
         case (ptl_pkg::csr_index_type'(csr_index))
            ptl_pkg::CSR_GAIN_P: gains_ff.gain_p <= csr_wdata;
            ptl_pkg::CSR_GAIN_I: gains_ff.gain_i <= csr_wdata;
            ptl_pkg::CSR_GAIN_D: gains_ff.gain_d <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage flow control
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic adv0, adv1, adv2, adv3, adv4, adv5;
   logic ld0, ld1, ld2, ld3, ld4, ld5;

   assign adv5 = !out_valid_ff || rsp_ch.ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign adv0 = !s0_valid_ff || adv1;

   assign ld0 = req_ch.valid && adv0;
   assign ld1 = s0_valid_ff && adv1;
   assign ld2 = s1_valid_ff && adv2;
   assign ld3 = s2_valid_ff && adv3;
   assign ld4 = s3_valid_ff && adv4;
   assign ld5 = s4_valid_ff && adv5;

   assign req_ch.ready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv0) s0_valid_ff  <= ld0;
         if (adv1) s1_valid_ff  <= ld1;
         if (adv2) s2_valid_ff  <= ld2;
         if (adv3) s3_valid_ff  <= ld3;
         if (adv4) s4_valid_ff  <= ld4;
         if (adv5) out_valid_ff <= ld5;
      end
   end

   // stage 0: input register
   logic [CW-1:0] tx0_ff, ty0_ff, sx0_ff, sy0_ff;

   always_ff @(posedge clock) begin
      if (ld0) begin
         tx0_ff <= req_ch.target_x;
         ty0_ff <= req_ch.target_y;
         sx0_ff <= req_ch.spot_x;
         sy0_ff <= req_ch.spot_y;
      end
   end

   // tracking and hit detection
   logic [CW-1:0] prev_sx_ff, prev_sy_ff;
   logic [HW-1:0] hits_ff;
   logic          trk0;
   logic          left_x, left_y, hit0;
   logic [HW-1:0] hits_in;

   assign trk0   = (sx0_ff != '0) && (sx0_ff < LIM) && (sy0_ff != '0) && (sy0_ff < LIM);
   assign left_x = (prev_sx_ff != '0) && (prev_sx_ff < LIM) && (sx0_ff > LIM);
   assign left_y = (prev_sy_ff != '0) && (prev_sy_ff < LIM) && (sy0_ff > LIM);
   assign hit0   = !trk0 && (left_x || left_y);
   assign hits_in = (hit0 && hits_ff != ptl_pkg::HITS_MAX) ? hits_ff + HW'(1) : hits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sx_ff <= '0;
         prev_sy_ff <= '0;
         hits_ff    <= '0;
      end else if (ld1) begin
         prev_sx_ff <= sx0_ff;
         prev_sy_ff <= sy0_ff;
         hits_ff    <= hits_in;
      end
   end

   // per-item flags carried alongside the axis stages
   logic          trk1_ff, trk2_ff, trk3_ff, trk4_ff;
   logic          hit1_ff, hit2_ff, hit3_ff, hit4_ff;
   logic [HW-1:0] hits1_ff, hits2_ff, hits3_ff, hits4_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         trk1_ff  <= trk0;
         hit1_ff  <= hit0;
         hits1_ff <= hits_in;
      end
      if (ld2) begin
         trk2_ff  <= trk1_ff;
         hit2_ff  <= hit1_ff;
         hits2_ff <= hits1_ff;
      end
      if (ld3) begin
         trk3_ff  <= trk2_ff;
         hit3_ff  <= hit2_ff;
         hits3_ff <= hits2_ff;
      end
      if (ld4) begin
         trk4_ff  <= trk3_ff;
         hit4_ff  <= hit3_ff;
         hits4_ff <= hits3_ff;
      end
   end

   // servo axes
   ptl_pkg::stage_ctrl_type ctrl;
   logic [ptl_pkg::ANGLE_W-1:0] pan_angle4, tilt_angle4;

   assign ctrl.ld1  = ld1;
   assign ctrl.ld2  = ld2;
   assign ctrl.ld3  = ld3;
   assign ctrl.ld4  = ld4;
   assign ctrl.trk0 = trk0;
   assign ctrl.trk3 = trk3_ff;

   ptl_axis_loop #(.ACC_BITS(ACC_BITS)) u_pan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .gains  (gains_ff),
      .target (tx0_ff),
      .spot   (sx0_ff),
      .angle  (pan_angle4)
   );

   ptl_axis_loop #(.ACC_BITS(ACC_BITS)) u_tilt (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .gains  (gains_ff),
      .target (ty0_ff),
      .spot   (sy0_ff),
      .angle  (tilt_angle4)
   );

   // output register
   logic [ptl_pkg::ANGLE_W-1:0] pan_angle_ff, tilt_angle_ff;
   logic [ptl_pkg::CMP_W-1:0]   pan_cmp_ff, tilt_cmp_ff;
   logic                        trk_out_ff, hit_out_ff;
   logic [HW-1:0]               hits_out_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         pan_angle_ff  <= pan_angle4;
         tilt_angle_ff <= tilt_angle4;
         pan_cmp_ff    <= ptl_pkg::compare_of(pan_angle4);
         tilt_cmp_ff   <= ptl_pkg::compare_of(tilt_angle4);
         trk_out_ff    <= trk4_ff;
         hit_out_ff    <= hit4_ff;
         hits_out_ff   <= hits4_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.pan_angle    = pan_angle_ff;
   assign rsp_ch.tilt_angle   = tilt_angle_ff;
   assign rsp_ch.pan_compare  = pan_cmp_ff;
   assign rsp_ch.tilt_compare = tilt_cmp_ff;
   assign rsp_ch.tracked      = trk_out_ff;
   assign rsp_ch.hit_pulse    = hit_out_ff;
   assign rsp_ch.hit_count    = hits_out_ff;

   // checks
   logic req_fire, rsp_tracked, rsp_hit, pan_cmp_ok;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign rsp_tracked = rsp_ch.valid && rsp_ch.tracked;
   assign rsp_hit     = rsp_ch.valid && rsp_ch.hit_pulse;
   assign pan_cmp_ok  = (rsp_ch.pan_compare >= ptl_pkg::CMP_BASE)
                     && (rsp_ch.pan_compare <= ptl_pkg::CMP_TOP);

   `PTL_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_fire, s0_valid_ff, "item lost")
   `PTL_ASSERT_IMPLIES(a_trk_no_hit, clock, reset, rsp_tracked, !rsp_ch.hit_pulse, "tracked hit")
   `PTL_ASSERT_IMPLIES(a_hit_cnt, clock, reset, rsp_hit, rsp_ch.hit_count != '0, "hit not counted")
   `PTL_ASSERT_IMPLIES(a_pan_cmp, clock, reset, rsp_ch.valid, pan_cmp_ok, "bad pan compare")

endmodule

// ----- tb/tb_pan_tilt_pid_laser_tracker_unit.sv -----
// Self-checking testbench for the pan/tilt PID laser tracker unit.
`timescale 1ns / 1ps

module tb_pan_tilt_pid_laser_tracker_unit;

   localparam int PAN   = 0;
   localparam int TILT  = 1;
   localparam int CW    = ptl_pkg::COORD_W;
   localparam int GW    = ptl_pkg::GAIN_W;
   localparam int ANW   = ptl_pkg::ANGLE_W;
   localparam int MW    = ptl_pkg::CMP_W;
   localparam int HW    = ptl_pkg::HITS_W;
   localparam int EW    = ptl_pkg::ERR_W;
   localparam int AW    = ptl_pkg::ACC_BITS_DEF;
   localparam int LIMIT = ptl_pkg::COORD_LIMIT_DEF;

   typedef struct packed {
      logic [CW-1:0] target_x;
      logic [CW-1:0] target_y;
      logic [CW-1:0] spot_x;
      logic [CW-1:0] spot_y;
   } frame_type;

   typedef struct packed {
      logic [ANW-1:0] pan_angle;
      logic [ANW-1:0] tilt_angle;
      logic [MW-1:0]  pan_compare;
      logic [MW-1:0]  tilt_compare;
      logic           tracked;
      logic           hit_pulse;
      logic [HW-1:0]  hit_count;
   } servo_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [ptl_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [GW-1:0]                   csr_wdata;

   ptl_req_if req_bus ();
   ptl_rsp_if rsp_bus ();

   pan_tilt_pid_laser_tracker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // tracker state as the testbench sees it
   logic signed [GW-1:0] kp, ki, kd;
   logic [ANW-1:0]       servo_pos [2];
   logic signed [AW-1:0] err_sum [2];
   logic signed [EW-1:0] last_err [2];
   logic [CW-1:0]        last_spot [2];
   logic [HW-1:0]        hit_total;

   frame_type pending_frames [$];
   servo_type expected_servo [$];
   servo_type want;

   int  mismatch_count = 0;
   int  req_gap_max    = 0;
   int  rsp_stall_max  = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   bit  frame_sent     = 1'b0;
   bit  result_taken   = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic in_field(input logic [CW-1:0] c);
      return (c != '0) && (int'(c) < LIMIT);
   endfunction

   function automatic logic [MW-1:0] pwm_compare(input logic [ANW-1:0] angle);
      int deg;
      int v;
      deg = int'(angle[ANW-1:ANW-CW]);
      v = 50 + deg * 200 / 180;
      return v[MW-1:0];
   endfunction

   task automatic run_axis(input int ax, input logic signed [EW-1:0] err);
      longint err_l, acc_l, derr_l, lim_l, mix_l, pos_l, top_l;
      err_l = err;
      lim_l = (longint'(1) <<< (AW - 1)) - 1;
      acc_l = err_sum[ax];
      acc_l = acc_l + err_l;
      if (acc_l > lim_l) acc_l = lim_l;
      if (acc_l < -lim_l - 1) acc_l = -lim_l - 1;
      err_sum[ax] = acc_l[AW-1:0];
      derr_l = last_err[ax];
      derr_l = err_l - derr_l;
      last_err[ax] = err;
      mix_l = kp * err_l + ki * acc_l + kd * derr_l;
      pos_l = longint'(servo_pos[ax]);
      top_l = longint'(ptl_pkg::ANGLE_MAX);
      pos_l = pos_l - (mix_l >>> ptl_pkg::FRAC_SHIFT);
      if (pos_l < 0) pos_l = 0;
      if (pos_l > top_l) pos_l = top_l;
      servo_pos[ax] = pos_l[ANW-1:0];
   endtask

   task automatic predict_servo(input frame_type f);
      servo_type            r;
      logic                 on_target;
      logic                 left_x, left_y;
      logic signed [EW-1:0] ex, ey;
      on_target = in_field(f.spot_x) && in_field(f.spot_y);
      r.hit_pulse = 1'b0;
      if (on_target) begin
         ex = $signed({1'b0, f.target_x}) - $signed({1'b0, f.spot_x});
         ey = $signed({1'b0, f.target_y}) - $signed({1'b0, f.spot_y});
         run_axis(PAN, ex);
         run_axis(TILT, ey);
      end else begin
         left_x = in_field(last_spot[PAN]) && (int'(f.spot_x) > LIMIT);
         left_y = in_field(last_spot[TILT]) && (int'(f.spot_y) > LIMIT);
         if (left_x || left_y) begin
            r.hit_pulse = 1'b1;
            if (hit_total != ptl_pkg::HITS_MAX) hit_total = hit_total + HW'(1);
         end
      end
      last_spot[PAN]  = f.spot_x;
      last_spot[TILT] = f.spot_y;
      r.pan_angle    = servo_pos[PAN];
      r.tilt_angle   = servo_pos[TILT];
      r.pan_compare  = pwm_compare(servo_pos[PAN]);
      r.tilt_compare = pwm_compare(servo_pos[TILT]);
      r.tracked      = on_target;
      r.hit_count    = hit_total;
      expected_servo.push_back(r);
   endtask

   task automatic report_mismatch(input string field, input int got, input int exp_val);
      $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, exp_val);
      mismatch_count++;
   endtask

   // driver: acceptance at the rising edge, new item at the falling edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_servo({req_bus.target_x, req_bus.target_y, req_bus.spot_x, req_bus.spot_y});
         frame_sent = 1'b1;
      end
   end

   always @(negedge clock) begin : drive_frames
      frame_type f;
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.target_x <= '0;
         req_bus.target_y <= '0;
         req_bus.spot_x   <= '0;
         req_bus.spot_y   <= '0;
      end else if (!req_bus.valid || frame_sent) begin
         frame_sent = 1'b0;
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (pending_frames.size() > 0) begin
            f = pending_frames.pop_front();
            req_bus.target_x <= f.target_x;
            req_bus.target_y <= f.target_y;
            req_bus.spot_x   <= f.spot_x;
            req_bus.spot_y   <= f.spot_y;
            req_bus.valid    <= 1'b1;
            gap_left = $urandom_range(0, req_gap_max);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_taken = 1'b1;
         if (expected_servo.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = expected_servo.pop_front();
            if (rsp_bus.pan_angle !== want.pan_angle)
               report_mismatch("pan_angle", int'(rsp_bus.pan_angle), int'(want.pan_angle));
            if (rsp_bus.tilt_angle !== want.tilt_angle)
               report_mismatch("tilt_angle", int'(rsp_bus.tilt_angle), int'(want.tilt_angle));
            if (rsp_bus.pan_compare !== want.pan_compare)
               report_mismatch("pan_compare", int'(rsp_bus.pan_compare),
                               int'(want.pan_compare));
            if (rsp_bus.tilt_compare !== want.tilt_compare)
               report_mismatch("tilt_compare", int'(rsp_bus.tilt_compare),
                               int'(want.tilt_compare));
            if (rsp_bus.tracked !== want.tracked)
               report_mismatch("tracked", int'(rsp_bus.tracked), int'(want.tracked));
            if (rsp_bus.hit_pulse !== want.hit_pulse)
               report_mismatch("hit_pulse", int'(rsp_bus.hit_pulse), int'(want.hit_pulse));
            if (rsp_bus.hit_count !== want.hit_count)
               report_mismatch("hit_count", int'(rsp_bus.hit_count), int'(want.hit_count));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (result_taken) begin
            result_taken = 1'b0;
            stall_left = $urandom_range(0, rsp_stall_max);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic push_frame(input logic [CW-1:0] tx, ty, sx, sy);
      pending_frames.push_back({tx, ty, sx, sy});
   endtask

   function automatic logic [CW-1:0] edge_coord();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd249;
         3: return 8'd250;
         4: return 8'd251;
         default: return 8'd255;
      endcase
   endfunction

   function automatic frame_type tracked_frame();
      frame_type f;
      f.target_x = CW'($urandom_range(0, 255));
      f.target_y = CW'($urandom_range(0, 255));
      f.spot_x   = CW'($urandom_range(1, LIMIT - 1));
      f.spot_y   = CW'($urandom_range(1, LIMIT - 1));
      return f;
   endfunction

   function automatic frame_type exit_frame();
      frame_type f;
      int        sel;
      f = tracked_frame();
      sel = $urandom_range(0, 2);
      f.spot_x = (sel != 1) ? CW'($urandom_range(LIMIT + 1, 255)) : CW'($urandom_range(0, 255));
      f.spot_y = (sel != 0) ? CW'($urandom_range(LIMIT + 1, 255)) : CW'($urandom_range(0, 255));
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      int        pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         f = tracked_frame();
      end else if (pick < 7) begin
         f = exit_frame();
      end else if (pick < 9) begin
         f = tracked_frame();
         f.spot_x = edge_coord();
         f.spot_y = edge_coord();
      end else begin
         f = $urandom();
      end
      return f;
   endfunction

   function automatic logic [GW-1:0] random_gain(input int span);
      int v;
      v = $urandom_range(0, 2 * span);
      v = v - span;
      return v[GW-1:0];
   endfunction

   task automatic queue_mix(input int n);
      repeat (n) pending_frames.push_back(random_frame());
   endtask

   task automatic wait_idle();
      while (pending_frames.size() != 0 || req_bus.valid || expected_servo.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input ptl_pkg::csr_index_type idx, input logic [GW-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         ptl_pkg::CSR_GAIN_P: kp = value;
         ptl_pkg::CSR_GAIN_I: ki = value;
         ptl_pkg::CSR_GAIN_D: kd = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_gains(input logic [GW-1:0] p, i, d);
      wait_idle();
      write_reg(ptl_pkg::CSR_GAIN_P, p);
      write_reg(ptl_pkg::CSR_GAIN_I, i);
      write_reg(ptl_pkg::CSR_GAIN_D, d);
   endtask

   task automatic set_idling(input int req_max, rsp_max);
      req_gap_max   = req_max;
      rsp_stall_max = rsp_max;
   endtask

   initial begin
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = ptl_pkg::CSR_GAIN_P;
      csr_wdata    = '0;

      kp = ptl_pkg::GAIN_P_RST;
      ki = ptl_pkg::GAIN_I_RST;
      kd = ptl_pkg::GAIN_D_RST;
      for (int a = 0; a < 2; a++) begin
         servo_pos[a] = ptl_pkg::ANGLE_MID;
         err_sum[a]   = '0;
         last_err[a]  = '0;
         last_spot[a] = '0;
      end
      hit_total = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items on the gains left by reset
      set_idling(3, 3);
      push_frame(0, 255, 1, 249);
      push_frame(255, 0, 249, 1);
      push_frame(128, 128, 251, 100);
      push_frame(128, 128, 100, 255);
      push_frame(0, 0, 0, 0);
      push_frame(255, 255, 255, 255);
      push_frame(90, 170, 128, 128);
      push_frame(90, 170, 250, 250);
      push_frame(60, 200, 128, 128);
      push_frame(60, 200, 250, 251);
      push_frame(0, 0, 249, 1);
      push_frame(0, 0, 255, 0);
      push_frame(255, 255, 1, 1);
      push_frame(100, 200, 100, 200);
      push_frame(17, 33, 0, 128);
      push_frame(17, 33, 128, 0);
      push_frame(17, 33, 1, 250);
      push_frame(17, 33, 255, 251);
      repeat (4) push_frame(255, 0, 1, 249);
      push_frame(170, 85, 85, 170);
      push_frame(85, 170, 170, 85);

      set_gains(16'h7fff, 16'h0000, 16'h0000);
      set_idling(5, 5);
      queue_mix(60);

      set_gains(16'h8000, 16'h8000, 16'h8000);
      set_idling(0, 0);
      queue_mix(60);

      set_gains(16'h0000, 16'h0000, 16'h0000);
      set_idling(5, 0);
      queue_mix(40);

      set_gains(16'h7fff, 16'h7fff, 16'h7fff);
      set_idling(0, 5);
      queue_mix(40);

      repeat (4) begin
         set_gains(random_gain(600), random_gain(20), random_gain(600));
         set_idling(5 * $urandom_range(0, 1), 5 * $urandom_range(0, 1));
         queue_mix(60);
      end

      // exits alternating between the axes, each one a hit, run the hit count to its ceiling
      set_gains(random_gain(400), random_gain(10), random_gain(400));
      set_idling(5, 5);
      pending_frames.push_back(tracked_frame());
      repeat (130) begin
         push_frame(17, 33, 255, 100);
         push_frame(17, 33, 100, 255);
      end
      queue_mix(120);

      // negative proportional gains with a unit integral gain
      set_gains(-16'sd4129, 16'h0001, 16'h0000);
      set_idling(2, 2);
      repeat (12) push_frame(255, 0, 1, 249);

      set_gains(-16'sd4212, 16'h0001, 16'h0000);
      repeat (12) push_frame(255, 0, 1, 249);

      wait_idle();
      repeat (12) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
